// ===== src/tma_pkg.sv =====
// Shared constants and types for the ticket mutex arbiter.
// Used by tma_cell and ticket_mutex_arbiter_core; no dependencies.
package tma_pkg;

    // default sizes
    localparam int MAX_REQUESTERS_DEF = 16;
    localparam int TICKET_BITS_DEF    = 8;

    // fixed field widths on the ports
    localparam int ID_W     = 5;
    localparam int TKO_W    = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // action codes
    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_HELD    = 2'd1,
        ST_NO_TKT  = 2'd2,
        ST_BAD_ID  = 2'd3
    } t_status;

endpackage

// ===== src/tma_cell.sv =====
// One requester cell of the arbiter: holds that requester's ticket and one
// stage of the oldest-ticket search chain. Depends on tma_pkg.
module tma_cell #(
    parameter int MAX_REQUESTERS = tma_pkg::MAX_REQUESTERS_DEF,
    parameter int TICKET_BITS    = tma_pkg::TICKET_BITS_DEF,
    parameter int IDX            = 0,
    parameter int OWN_W          = $clog2(MAX_REQUESTERS + 1),
    parameter int CNT_W          = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // ticket update
    input  logic                   i_wr_en,
    input  logic [TICKET_BITS-1:0] i_wr_ticket,
    input  logic [CNT_W-1:0]       i_eff_count,
    input  logic [TICKET_BITS-1:0] i_next_ticket,
    output logic                   o_held,
    // search record from the previous cell
    input  logic                   i_found,
    input  logic [OWN_W-1:0]       i_best_id,
    input  logic [TICKET_BITS-1:0] i_best_tk,
    input  logic [TICKET_BITS-1:0] i_best_age,
    // search record to the next cell
    output logic                   o_found,
    output logic [OWN_W-1:0]       o_best_id,
    output logic [TICKET_BITS-1:0] o_best_tk,
    output logic [TICKET_BITS-1:0] o_best_age
);

    localparam logic [CNT_W-1:0] MY_NUM = CNT_W'(IDX + 1);

    logic [TICKET_BITS-1:0] r_held;
    logic                   r_found;
    logic [OWN_W-1:0]       r_best_id;
    logic [TICKET_BITS-1:0] r_best_tk;
    logic [TICKET_BITS-1:0] r_best_age;

    logic                   active;
    logic [TICKET_BITS-1:0] age;
    logic                   take;

    // age counted back from next ticket, modulo 2^B-1 (ticket 0 unused)
    always_comb begin
        active = (MY_NUM <= i_eff_count);
        age    = i_next_ticket - r_held;
        if (i_next_ticket < r_held) begin
            age = age - TICKET_BITS'(1);
        end
        // strictly older wins, so the lower id keeps a tie
        take = active && (r_held != '0) && (!i_found || (age > i_best_age));
    end

    // stored ticket
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_wr_en) begin
            r_held <= i_wr_ticket;
        end
    end

    // search stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= i_found || take;
        end
        if (take) begin
            r_best_id  <= OWN_W'(IDX + 1);
            r_best_tk  <= r_held;
            r_best_age <= age;
        end else begin
            r_best_id  <= i_best_id;
            r_best_tk  <= i_best_tk;
            r_best_age <= i_best_age;
        end
    end

    assign o_held     = (r_held != '0);
    assign o_found    = r_found;
    assign o_best_id  = r_best_id;
    assign o_best_tk  = r_best_tk;
    assign o_best_age = r_best_age;

endmodule

// ===== src/ticket_mutex_arbiter_core.sv =====
// Top level of the ticket mutex arbiter: request decode, ticket counter,
// control sequencer and a chain of tma_cell. Depends on tma_pkg, tma_cell.
//
// Usage: each input word is one request. tuser carries the action (acquire
// or release), tdata the 1-based requester id. Every request returns one
// result word: current owner, owner's ticket, the ticket just issued, and
// a status code in tuser. The config channel sets how many requesters are
// in use; write it only while no request is in flight.
// The ticket table and counter are updated on the accepting edge; the
// oldest-ticket search then ripples one cell per cycle through the
// MAX_REQUESTERS cells. One request is processed at a time: the input is
// not ready again until the search for the last one has finished.
// A finished result sits in the output register; a new request is taken
// while it waits. If the receiver stalls long enough for the next search to
// finish too, that result is held inside and the input stays not ready.
// Reset (synchronous, active low) clears all tickets, sets the next ticket
// to 1 and the requester count to 16.
module ticket_mutex_arbiter_core #(
    parameter int MAX_REQUESTERS = tma_pkg::MAX_REQUESTERS_DEF,
    parameter int TICKET_BITS    = tma_pkg::TICKET_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request stream
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [7:0]                i_s_axis_tdata,   // [4:0] requester
    input  logic                      i_s_axis_tuser,   // [0] action
    // result stream
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [23:0]               o_m_axis_tdata,   // [4:0] owner,
                                                        // [12:5] owner_ticket,
                                                        // [20:13] issued_ticket
    output logic [1:0]                o_m_axis_tuser,   // [1:0] status
    // config write
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [tma_pkg::CFG_W-1:0] i_cfg_data       // requesters_in_use
);

    localparam int OWN_W  = $clog2(MAX_REQUESTERS + 1);
    localparam int CNT_W0 = $clog2(MAX_REQUESTERS + 1);
    localparam int CNT_W  = (CNT_W0 > tma_pkg::ID_W) ? CNT_W0 : tma_pkg::ID_W;
    localparam int TKX_W  = (TICKET_BITS > tma_pkg::TKO_W) ? TICKET_BITS : tma_pkg::TKO_W;
    localparam int SCN_W  = $clog2(MAX_REQUESTERS + 1);
    localparam logic [SCN_W-1:0] SCAN_LAST = SCN_W'(MAX_REQUESTERS);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_REQUESTERS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    t_state                    r_state;
    logic [SCN_W-1:0]          r_scan_cnt;
    logic [tma_pkg::CFG_W-1:0] r_cfg;
    logic [TICKET_BITS-1:0]    r_next_ticket;
    logic [tma_pkg::TKO_W-1:0] r_issued;
    tma_pkg::t_status          r_status;
    logic                      r_out_valid;
    logic [23:0]               r_out_data;
    logic [1:0]                r_out_user;

    // chain wiring: index k feeds cell k
    logic                   ch_found [MAX_REQUESTERS+1];
    logic [OWN_W-1:0]       ch_id    [MAX_REQUESTERS+1];
    logic [TICKET_BITS-1:0] ch_tk    [MAX_REQUESTERS+1];
    logic [TICKET_BITS-1:0] ch_age   [MAX_REQUESTERS+1];

    logic [MAX_REQUESTERS-1:0] hit;
    logic [MAX_REQUESTERS-1:0] held;
    logic [MAX_REQUESTERS-1:0] wr_en;

    logic                   accept;
    logic [CNT_W-1:0]       req_id;
    logic [CNT_W-1:0]       cfg_ext;
    logic [CNT_W-1:0]       eff_count;
    logic                   hit_held;
    tma_pkg::t_status       req_status;
    logic [TICKET_BITS-1:0] wr_ticket;
    logic [TICKET_BITS-1:0] next_inc;
    logic [TKX_W-1:0]       issued_ext;
    logic [TKX_W-1:0]       owner_tk_ext;
    logic [CNT_W-1:0]       owner_ext;
    logic [23:0]            result_data;
    logic                   out_free;
    logic                   load_out;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // result ready to move into the output register
    assign load_out = out_free && (((r_state == S_SCAN) && (r_scan_cnt == SCAN_LAST))
                                   || (r_state == S_HOLD));

    // request decode and status
    always_comb begin
        req_id    = CNT_W'(i_s_axis_tdata[tma_pkg::ID_W-1:0]);
        cfg_ext   = CNT_W'(r_cfg);
        eff_count = (cfg_ext < MAX_CNT) ? cfg_ext : MAX_CNT;
        hit_held  = |(hit & held);
        if ((req_id == '0) || (req_id > eff_count)) begin
            req_status = tma_pkg::ST_BAD_ID;
        end else if (i_s_axis_tuser == tma_pkg::ACT_ACQUIRE) begin
            req_status = hit_held ? tma_pkg::ST_HELD : tma_pkg::ST_OK;
        end else begin
            req_status = hit_held ? tma_pkg::ST_OK : tma_pkg::ST_NO_TKT;
        end
        wr_ticket = (i_s_axis_tuser == tma_pkg::ACT_ACQUIRE) ? r_next_ticket : '0;
        next_inc  = (r_next_ticket == '1) ? TICKET_BITS'(1)
                                          : r_next_ticket + TICKET_BITS'(1);
        if ((req_status == tma_pkg::ST_OK) && (i_s_axis_tuser == tma_pkg::ACT_ACQUIRE)) begin
            issued_ext = TKX_W'(r_next_ticket);
        end else begin
            issued_ext = '0;
        end
    end

    // per-cell address match and write strobe
    always_comb begin
        for (int i = 0; i < MAX_REQUESTERS; i++) begin
            hit[i]   = (req_id == CNT_W'(i + 1));
            wr_en[i] = accept && (req_status == tma_pkg::ST_OK) && hit[i];
        end
    end

    // search seed: nothing found yet
    assign ch_found[0] = 1'b0;
    assign ch_id[0]    = '0;
    assign ch_tk[0]    = '0;
    assign ch_age[0]   = '0;

    for (genvar g = 0; g < MAX_REQUESTERS; g++) begin : g_cell
        tma_cell #(
            .MAX_REQUESTERS (MAX_REQUESTERS),
            .TICKET_BITS    (TICKET_BITS),
            .IDX            (g),
            .OWN_W          (OWN_W),
            .CNT_W          (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_wr_en       (wr_en[g]),
            .i_wr_ticket   (wr_ticket),
            .i_eff_count   (eff_count),
            .i_next_ticket (r_next_ticket),
            .o_held        (held[g]),
            .i_found       (ch_found[g]),
            .i_best_id     (ch_id[g]),
            .i_best_tk     (ch_tk[g]),
            .i_best_age    (ch_age[g]),
            .o_found       (ch_found[g+1]),
            .o_best_id     (ch_id[g+1]),
            .o_best_tk     (ch_tk[g+1]),
            .o_best_age    (ch_age[g+1])
        );
    end

    // result word from the end of the chain
    always_comb begin
        owner_ext    = ch_found[MAX_REQUESTERS] ? CNT_W'(ch_id[MAX_REQUESTERS]) : '0;
        owner_tk_ext = ch_found[MAX_REQUESTERS] ? TKX_W'(ch_tk[MAX_REQUESTERS]) : '0;
        result_data  = {3'b000, r_issued, owner_tk_ext[tma_pkg::TKO_W-1:0],
                        owner_ext[tma_pkg::ID_W-1:0]};
    end

    // config register and ticket counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= tma_pkg::CFG_RESET;
            r_next_ticket <= TICKET_BITS'(1);
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (accept && (req_status == tma_pkg::ST_OK)
                    && (i_s_axis_tuser == tma_pkg::ACT_ACQUIRE)) begin
                r_next_ticket <= next_inc;
            end
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out_data  <= result_data;
                r_out_user  <= r_status;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state    <= S_SCAN;
                        r_scan_cnt <= '0;
                        r_issued   <= issued_ext[tma_pkg::TKO_W-1:0];
                        r_status   <= req_status;
                    end
                end
                S_SCAN: begin
                    if (r_scan_cnt != SCAN_LAST) begin
                        r_scan_cnt <= r_scan_cnt + SCN_W'(1);
                    end else if (out_free) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    // chain output stays stable while the table is unchanged
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

// ===== sim/ticket_mutex_arbiter_core_test.sv =====
// Testbench for ticket_mutex_arbiter_core: random and directed lock requests,
// with the arbiter's ticket table and counter tracked in the bench for checking.
// Depends on tma_pkg and ticket_mutex_arbiter_core.
module ticket_mutex_arbiter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NREQ       = 16;
    localparam int TKT_SPAN   = 255;      // tickets run 1..255
    localparam int LONG_HOLD  = 400;      // receiver stall, well past two results
    localparam int DRAIN_WAIT = 40;       // extra wait after the bench is drained
    localparam int CYCLE_CAP  = 500000;

    typedef struct packed {
        logic       act;
        logic [4:0] id;
    } t_lock_req;

    typedef struct packed {
        logic [4:0]       owner;
        logic [7:0]       owner_tk;
        logic [7:0]       issued;
        tma_pkg::t_status status;
    } t_grant;

    // clock, reset, ports
    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [7:0]  req_data  = '0;     // [4:0] requester
    logic        req_user  = 1'b0;   // [0] action
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [23:0] res_data;           // [4:0] owner, [12:5] owner ticket, [20:13] issued
    logic [1:0]  res_user;           // [1:0] status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data  = '0;

    ticket_mutex_arbiter_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_user),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tuser  (res_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    // bench-side copy of the arbiter state
    logic [7:0] held_tk [NREQ];
    logic [7:0] next_tk;
    logic [4:0] in_use;

    t_grant    grants_due[$];
    t_lock_req pending_reqs[$];

    // stimulus planning: who holds a ticket, and the count in force
    bit         plan_holds [NREQ+1];
    int         plan_count = NREQ;

    int  mismatches  = 0;
    int  cycles      = 0;
    int  idle_pct    = 0;      // chance in percent of starting an idle burst
    int  hold_asks   = 0;
    int  hold_served = 0;
    int  hold_left   = 0;
    int  rx_gap      = 0;
    int  tx_gap      = 0;
    bit  req_taken   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // age of ticket t counted back from the next ticket
    function automatic int ticket_age(logic [7:0] t);
        int n;
        int tv;
        int d;
        n  = int'(next_tk);
        tv = int'(t);
        d  = (n >= tv) ? n - tv : n + TKT_SPAN - tv;
        return d % TKT_SPAN;
    endfunction

    // apply one request to the copy and report the resulting owner
    function automatic t_grant serve_request(logic act, logic [4:0] id);
        t_grant g;
        int     lim;
        int     best_age;
        int     a;
        lim      = (int'(in_use) < NREQ) ? int'(in_use) : NREQ;
        g        = '0;
        g.status = tma_pkg::ST_OK;
        best_age = 0;
        if (id == 0 || int'(id) > lim) begin
            g.status = tma_pkg::ST_BAD_ID;
        end else if (act == tma_pkg::ACT_ACQUIRE) begin
            if (held_tk[id-1] != 0) begin
                g.status = tma_pkg::ST_HELD;
            end else begin
                g.issued       = next_tk;
                held_tk[id-1]  = next_tk;
                next_tk        = (next_tk == 8'hff) ? 8'd1 : next_tk + 8'd1;
            end
        end else begin
            if (held_tk[id-1] == 0)
                g.status = tma_pkg::ST_NO_TKT;
            else
                held_tk[id-1] = '0;
        end
        // oldest ticket wins, lower id on a tie
        for (int i = 0; i < lim; i++) begin
            if (held_tk[i] != 0) begin
                a = ticket_age(held_tk[i]);
                if (g.owner == 0 || a > best_age) begin
                    g.owner    = 5'(i + 1);
                    g.owner_tk = held_tk[i];
                    best_age   = a;
                end
            end
        end
        return g;
    endfunction

    task automatic flag_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    // monitor: check results, then track accepted requests and config writes
    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            for (int i = 0; i < NREQ; i++) held_tk[i] = '0;
            next_tk   = 8'd1;
            in_use    = tma_pkg::CFG_RESET;
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_valid && req_ready;
            if (res_valid && res_ready) begin
                if (grants_due.size() == 0) begin
                    flag_mismatch("unexpected result word, owner", 0, int'(res_data[4:0]));
                end else begin
                    want = grants_due.pop_front();
                    if (res_data[4:0] != want.owner)
                        flag_mismatch("owner", int'(want.owner), int'(res_data[4:0]));
                    if (res_data[12:5] != want.owner_tk)
                        flag_mismatch("owner ticket", int'(want.owner_tk),
                                      int'(res_data[12:5]));
                    if (res_data[20:13] != want.issued)
                        flag_mismatch("issued ticket", int'(want.issued),
                                      int'(res_data[20:13]));
                    if (res_user != want.status)
                        flag_mismatch("status", int'(want.status), int'(res_user));
                end
            end
            if (cfg_valid && cfg_ready)
                in_use = cfg_data;
            if (req_valid && req_ready)
                grants_due.push_back(serve_request(req_user, req_data[4:0]));
        end
    end

    // request driver, fed from the pending queue
    always @(negedge i_clk) begin
        t_lock_req r;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || req_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                req_valid <= 1'b0;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                tx_gap = $urandom_range(0, 7);
                req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                req_valid <= 1'b1;
                req_data  <= {3'b000, r.id};
                req_user  <= r.act;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus a long hold-off when one is asked for
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else if (hold_asks != hold_served) begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            res_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            res_ready <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            rx_gap = $urandom_range(0, 7);
            res_ready <= 1'b0;
        end else begin
            res_ready <= 1'b1;
        end
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    // queue a request and keep the planning copy of who holds a ticket
    task automatic queue_req(logic act, logic [4:0] id);
        int lim;
        lim = (plan_count < NREQ) ? plan_count : NREQ;
        if (id != 0 && int'(id) <= lim) begin
            if (act == tma_pkg::ACT_ACQUIRE)
                plan_holds[id] = 1'b1;
            else
                plan_holds[id] = 1'b0;
        end
        pending_reqs.push_back(t_lock_req'{act: act, id: id});
    endtask

    // block until every queued request is in and every result is out
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_reqs.size() > 0 || req_valid || grants_due.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic write_in_use(logic [4:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid  <= 1'b0;
        plan_count = int'(v);
    endtask

    // mostly well-formed traffic, some wrong actions and bad ids
    task automatic queue_random(int n);
        int         lim;
        int         r;
        logic [4:0] id;
        logic       act;
        lim = (plan_count < NREQ) ? plan_count : NREQ;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (lim == 0 || r < 8) begin
                id  = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(lim + 1, 31));
                act = 1'($urandom_range(0, 1));
            end else begin
                id  = 5'($urandom_range(1, lim));
                act = plan_holds[id] ? tma_pkg::ACT_RELEASE : tma_pkg::ACT_ACQUIRE;
                if (r < 20) act = ~act;
            end
            queue_req(act, id);
        end
    endtask

    initial begin
        int phase_counts [12] = '{16, 1, 2, 0, 31, 7, 16, 3, 12, 16, 9, 16};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // errors, ordering, cancel of a waiting requester
        idle_pct = 20;
        queue_req(tma_pkg::ACT_RELEASE, 5'd1);     // nothing to release
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd0);     // id zero
        queue_req(tma_pkg::ACT_RELEASE, 5'd0);
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd17);    // above the count
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd31);
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd1);
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd16);
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd1);     // already holding
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd8);
        queue_req(tma_pkg::ACT_RELEASE, 5'd16);    // waiter gives up
        queue_req(tma_pkg::ACT_RELEASE, 5'd1);     // ownership moves on
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd1);
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd16);
        queue_req(tma_pkg::ACT_RELEASE, 5'd8);
        queue_req(tma_pkg::ACT_RELEASE, 5'd1);

        // a ticket above the count stays hidden, then shows again
        write_in_use(5'd4);
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd2);
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd16);
        queue_req(tma_pkg::ACT_RELEASE, 5'd2);
        write_in_use(5'd0);               // every id is bad
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd1);
        queue_req(tma_pkg::ACT_RELEASE, 5'd1);
        write_in_use(5'd31);              // clipped to the full set
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd3);
        queue_req(tma_pkg::ACT_ACQUIRE, 5'd16);
        queue_req(tma_pkg::ACT_RELEASE, 5'd16);
        queue_req(tma_pkg::ACT_RELEASE, 5'd3);

        // random phases over a range of counts
        for (int p = 0; p < 12; p++) begin
            write_in_use(5'(phase_counts[p]));
            idle_pct = (p == 11 || p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 40);
            if (p == 6) hold_asks++;
            queue_random(phase_counts[p] == 0 ? 30 : 160);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && grants_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
